/* sv/tlw_pkg.sv */
// Shared types, constants and band tables for the taxonomy lineage walk.
// No dependencies; every module of the block imports this package.
package tlw_pkg;

    localparam int NODES     = 65536;
    localparam int NODE_AW   = $clog2(NODES);
    localparam int MAX_STEPS = 30;
    localparam int STEP_W    = $clog2(MAX_STEPS + 1);
    localparam int BANDS     = 7;
    localparam int BAND_W    = 3;
    localparam int CQ_DEPTH  = 4;
    localparam int CQ_AW     = $clog2(CQ_DEPTH);

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        logic        cmd;
        logic [15:0] node_index;
        logic [30:0] entry_taxid;
        logic [4:0]  entry_rank;
        logic [15:0] entry_parent;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  level;
        logic [30:0] lineage_taxid;
        logic [4:0]  lineage_rank;
        logic        found;
        logic        last;
    } result_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] node_index;
        logic [30:0] taxid;
        logic [4:0]  rank;
        logic [15:0] parent;
    } cmd_t;

    typedef struct packed {
        logic [30:0] taxid;
        logic [4:0]  rank;
        logic [15:0] parent;
    } node_t;

    localparam logic [4:0] BAND_LOW   [BANDS] = '{5'd24, 5'd20, 5'd17, 5'd12, 5'd8, 5'd5, 5'd2};
    localparam logic [4:0] BAND_HIGH  [BANDS] = '{5'd27, 5'd23, 5'd19, 5'd16, 5'd11, 5'd7, 5'd4};
    localparam logic [4:0] BAND_CANON [BANDS] = '{5'd24, 5'd22, 5'd18, 5'd13, 5'd9, 5'd6, 5'd3};

    function automatic logic node_in_range(input logic [15:0] idx);
        return (32'(idx) < NODES);
    endfunction

endpackage

/* sv/tlw_front.sv */
// Front end: accepts input beats, classifies them into commands and queues them.
// Depends on tlw_pkg.
module tlw_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  tlw_pkg::in_item_t item,
    output logic             cmd_valid,
    output tlw_pkg::cmd_t    cmd,
    input  logic             cmd_take
);
    import tlw_pkg::*;

    cmd_t             q_mem [CQ_DEPTH];
    logic [CQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CQ_AW:0]   count_reg, count_next;
    logic             do_push, do_pop;
    cmd_t             classified;

    always_comb
    begin
        classified.kind       = item.cmd ? CMD_QUERY : CMD_LOAD;
        classified.node_index = item.node_index;
        classified.taxid      = item.entry_taxid;
        classified.rank       = item.entry_rank;
        classified.parent     = item.entry_parent;
    end

    assign full      = (count_reg == (CQ_AW+1)'(CQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= classified;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* sv/tlw_walk.sv */
// Back end: node tables, parent-link walker, rank bands and result register.
// Depends on tlw_pkg.
module tlw_walk (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  tlw_pkg::cmd_t   cmd,
    output logic            cmd_take,
    output logic            empty,
    input  logic            pop,
    output tlw_pkg::result_t result
);
    import tlw_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_START = 4'b0010,
        ST_WALK  = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    node_t              node_mem [NODES];
    node_t              rd_reg;
    logic               rd_range_reg;
    logic               mem_we, mem_re, re_range;
    logic [NODE_AW-1:0] rd_addr;
    node_t              eff;

    state_t             state_reg, state_next;
    logic [15:0]        cur_reg, cur_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [BAND_W-1:0]  sel_reg, sel_next;
    logic [30:0]        bt_reg [BANDS];
    logic [30:0]        bt_next [BANDS];
    logic [4:0]         br_reg [BANDS];
    logic [4:0]         br_next [BANDS];
    logic [BANDS-1:0]   bf_reg, bf_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;
    logic               slot_free;

    assign eff       = rd_range_reg ? rd_reg : '0;
    assign empty     = !out_valid_reg;
    assign result    = out_reg;
    assign slot_free = !out_valid_reg || pop;

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        step_next      = step_reg;
        sel_next       = sel_reg;
        bt_next        = bt_reg;
        br_next        = br_reg;
        bf_next        = bf_reg;
        out_valid_next = pop ? 1'b0 : out_valid_reg;
        out_next       = out_reg;
        cmd_take       = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        re_range       = 1'b0;
        rd_addr        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take = 1'b1;
                    if (cmd.kind == CMD_LOAD)
                    begin
                        mem_we = node_in_range(cmd.node_index);
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        re_range   = node_in_range(cmd.node_index);
                        rd_addr    = cmd.node_index[NODE_AW-1:0];
                        cur_next   = cmd.node_index;
                        step_next  = '0;
                        bf_next    = '0;
                        for (int b = 0; b < BANDS; b++)
                        begin
                            bt_next[b] = '0;
                            br_next[b] = '0;
                        end
                        state_next = ST_START;
                    end
                end
            end
            ST_START:
            begin
                if (slot_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next.level         = 3'd0;
                    out_next.lineage_taxid = eff.taxid;
                    out_next.lineage_rank  = eff.rank;
                    out_next.found         = rd_range_reg;
                    out_next.last          = 1'b0;
                    state_next             = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (cur_reg == '0 || step_reg == STEP_W'(MAX_STEPS))
                begin
                    sel_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    for (int b = 0; b < BANDS; b++)
                    begin
                        if (eff.rank >= BAND_LOW[b] && eff.rank <= BAND_HIGH[b]
                            && !(bf_reg[b] && br_reg[b] == BAND_CANON[b]))
                        begin
                            bf_next[b] = 1'b1;
                            br_next[b] = eff.rank;
                            bt_next[b] = eff.taxid;
                        end
                    end
                    mem_re    = 1'b1;
                    re_range  = node_in_range(eff.parent);
                    rd_addr   = eff.parent[NODE_AW-1:0];
                    cur_next  = eff.parent;
                    step_next = step_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next.level         = 3'(sel_reg) + 3'd1;
                    out_next.lineage_taxid = bt_reg[sel_reg];
                    out_next.lineage_rank  = br_reg[sel_reg];
                    out_next.found         = bf_reg[sel_reg];
                    out_next.last          = (sel_reg == BAND_W'(BANDS - 1));
                    if (sel_reg == BAND_W'(BANDS - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        sel_next = sel_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            node_mem[cmd.node_index[NODE_AW-1:0]] <= '{taxid:  cmd.taxid,
                                                       rank:   cmd.rank,
                                                       parent: cmd.parent};
        end
        if (mem_re)
        begin
            rd_reg       <= node_mem[rd_addr];
            rd_range_reg <= re_range;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        bt_reg   <= bt_next;
        br_reg   <= br_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            sel_reg       <= '0;
            bf_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            sel_reg       <= sel_next;
            bf_reg        <= bf_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* sv/taxonomy_lineage_walk.sv */
// Top level of the taxonomy lineage walk: front end, command queue and walker.
// Depends on tlw_pkg, tlw_front and tlw_walk.
//
// A load beat writes one node (taxid, rank, parent) into the node tables and
// yields no result; it leaves the command queue once the walker is idle. A query
// beat yields eight results: the start node, then species, genus, family,
// order, class, phylum and kingdom. The walker visits at most 30 nodes, ending
// at the root, node 0: it reads one table entry per cycle through the single
// port of the node memory, and the result register drains one beat per cycle
// while results are popped.
// A four-deep command queue keeps accepting beats while a query runs. Node
// entries are undefined until loaded, and only loaded nodes may be reached.
module taxonomy_lineage_walk (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  tlw_pkg::in_item_t item,
    output logic             empty,
    input  logic             pop,
    output tlw_pkg::result_t result
);
    import tlw_pkg::*;

    logic cmd_valid;
    logic cmd_take;
    cmd_t cmd;

    tlw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    tlw_walk u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule
